### src/sitdd_pkg.sv
// Shared types and constants for the signed integer to decimal digit converter.
`timescale 1ns / 1ps

package sitdd_pkg;

    localparam int VALUE_W     = 32;
    localparam int DIGIT_W     = 4;
    localparam int DIGITS      = 10;
    localparam int BCD_W       = DIGITS * DIGIT_W;
    localparam int COUNT_W     = 4;
    localparam int STAGE_BITS  = 8;
    localparam int DABBLE_STGS = VALUE_W / STAGE_BITS;

    typedef struct packed {
        logic               valid;
        logic               non_negative;
        logic [BCD_W-1:0]   bcd;
        logic [VALUE_W-1:0] bin;
    } stage_t;

    typedef struct packed {
        logic               valid;
        logic               non_negative;
        logic [COUNT_W-1:0] digit_count;
        logic [BCD_W-1:0]   digits;
    } result_t;

endpackage

### src/sitdd_dabble_stage.sv
// One pipeline stage of the shift-and-add-3 conversion, eight binary bits per stage.
`timescale 1ns / 1ps

module sitdd_dabble_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  sitdd_pkg::stage_t in_s,
    output sitdd_pkg::stage_t out_s
);

    logic                          valid_reg;
    logic                          non_negative_reg;
    logic [sitdd_pkg::BCD_W-1:0]   bcd_reg;
    logic [sitdd_pkg::VALUE_W-1:0] bin_reg;
    logic [sitdd_pkg::BCD_W-1:0]   bcd_next;
    logic [sitdd_pkg::VALUE_W-1:0] bin_next;

    always_comb
    begin
        logic [sitdd_pkg::BCD_W-1:0]   b;
        logic [sitdd_pkg::VALUE_W-1:0] v;
        b = in_s.bcd;
        v = in_s.bin;
        for (int i = 0; i < sitdd_pkg::STAGE_BITS; i++)
        begin
            for (int j = 0; j < sitdd_pkg::DIGITS; j++)
            begin
                if (b[j*sitdd_pkg::DIGIT_W +: sitdd_pkg::DIGIT_W] >= 4'd5)
                begin
                    b[j*sitdd_pkg::DIGIT_W +: sitdd_pkg::DIGIT_W] =
                        b[j*sitdd_pkg::DIGIT_W +: sitdd_pkg::DIGIT_W] + 4'd3;
                end
            end
            b = {b[sitdd_pkg::BCD_W-2:0], v[sitdd_pkg::VALUE_W-1]};
            v = {v[sitdd_pkg::VALUE_W-2:0], 1'b0};
        end
        bcd_next = b;
        bin_next = v;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_s.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        non_negative_reg <= in_s.non_negative;
        bcd_reg          <= bcd_next;
        bin_reg          <= bin_next;
    end

    assign out_s.valid        = valid_reg;
    assign out_s.non_negative = non_negative_reg;
    assign out_s.bcd          = bcd_reg;
    assign out_s.bin          = bin_reg;

endmodule

### src/sitdd_align.sv
// Final stage: counts significant digits and left-justifies them.
`timescale 1ns / 1ps

module sitdd_align
(
    input  logic               clk,
    input  logic               rst_n,
    input  sitdd_pkg::stage_t  in_s,
    output sitdd_pkg::result_t out_r
);

    localparam logic [sitdd_pkg::COUNT_W-1:0] MaxDigits =
        sitdd_pkg::COUNT_W'(sitdd_pkg::DIGITS);

    logic                           valid_reg;
    logic                           non_negative_reg;
    logic [sitdd_pkg::COUNT_W-1:0]  count_reg;
    logic [sitdd_pkg::BCD_W-1:0]    digits_reg;
    logic [sitdd_pkg::COUNT_W-1:0]  count_next;
    logic [sitdd_pkg::BCD_W-1:0]    digits_next;

    always_comb
    begin
        logic [sitdd_pkg::COUNT_W-1:0] lz;
        logic                          found;
        lz    = '0;
        found = 1'b0;
        // leading zero digits, at most DIGITS-1 so zero keeps one digit
        for (int j = sitdd_pkg::DIGITS - 1; j > 0; j--)
        begin
            if (!found && in_s.bcd[j*sitdd_pkg::DIGIT_W +: sitdd_pkg::DIGIT_W] == '0)
            begin
                lz = lz + 1'b1;
            end
            else
            begin
                found = 1'b1;
            end
        end
        count_next  = MaxDigits - lz;
        digits_next = in_s.bcd << {lz, 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_s.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        non_negative_reg <= in_s.non_negative;
        count_reg        <= count_next;
        digits_reg       <= digits_next;
    end

    assign out_r.valid        = valid_reg;
    assign out_r.non_negative = non_negative_reg;
    assign out_r.digit_count  = count_reg;
    assign out_r.digits       = digits_reg;

endmodule

### src/signed_int32_to_decimal_digits.sv
// Top level of the signed 32-bit to decimal digit converter.
`timescale 1ns / 1ps

// Fully pipelined: a transaction is taken whenever start is high, every cycle if
// wanted, and busy never rises. done rises when the value has passed the stages
// in order: one stage forms the magnitude, four stages of shift-and-add-3 take
// eight bits each, and one stage counts and left-justifies the digits. done lasts
// one cycle per transaction and cannot be held off, so the receiver must take
// each result in that cycle.
module signed_int32_to_decimal_digits
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [sitdd_pkg::VALUE_W-1:0] value,
    output logic                            done,
    output logic                            non_negative,
    output logic [sitdd_pkg::COUNT_W-1:0]   digit_count,
    output logic [sitdd_pkg::DIGIT_W-1:0]   digit_0,
    output logic [sitdd_pkg::DIGIT_W-1:0]   digit_1,
    output logic [sitdd_pkg::DIGIT_W-1:0]   digit_2,
    output logic [sitdd_pkg::DIGIT_W-1:0]   digit_3,
    output logic [sitdd_pkg::DIGIT_W-1:0]   digit_4,
    output logic [sitdd_pkg::DIGIT_W-1:0]   digit_5,
    output logic [sitdd_pkg::DIGIT_W-1:0]   digit_6,
    output logic [sitdd_pkg::DIGIT_W-1:0]   digit_7,
    output logic [sitdd_pkg::DIGIT_W-1:0]   digit_8,
    output logic [sitdd_pkg::DIGIT_W-1:0]   digit_9
);

    localparam int DW = sitdd_pkg::DIGIT_W;

    logic                          valid_reg;
    logic                          non_negative_reg;
    logic [sitdd_pkg::VALUE_W-1:0] mag_reg;
    logic [sitdd_pkg::VALUE_W-1:0] mag_next;

    sitdd_pkg::stage_t  stg [sitdd_pkg::DABBLE_STGS+1];
    sitdd_pkg::result_t res;

    assign busy     = 1'b0;
    assign mag_next = value[sitdd_pkg::VALUE_W-1] ? (~value + 1'b1) : value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        non_negative_reg <= ~value[sitdd_pkg::VALUE_W-1];
        mag_reg          <= mag_next;
    end

    assign stg[0].valid        = valid_reg;
    assign stg[0].non_negative = non_negative_reg;
    assign stg[0].bcd          = '0;
    assign stg[0].bin          = mag_reg;

    for (genvar g = 0; g < sitdd_pkg::DABBLE_STGS; g++)
    begin : g_dabble
        sitdd_dabble_stage u_stage
        (
            .clk   (clk),
            .rst_n (rst_n),
            .in_s  (stg[g]),
            .out_s (stg[g+1])
        );
    end

    sitdd_align u_align
    (
        .clk   (clk),
        .rst_n (rst_n),
        .in_s  (stg[sitdd_pkg::DABBLE_STGS]),
        .out_r (res)
    );

    assign done         = res.valid;
    assign non_negative = res.non_negative;
    assign digit_count  = res.digit_count;
    assign digit_0      = res.digits[9*DW +: DW];
    assign digit_1      = res.digits[8*DW +: DW];
    assign digit_2      = res.digits[7*DW +: DW];
    assign digit_3      = res.digits[6*DW +: DW];
    assign digit_4      = res.digits[5*DW +: DW];
    assign digit_5      = res.digits[4*DW +: DW];
    assign digit_6      = res.digits[3*DW +: DW];
    assign digit_7      = res.digits[2*DW +: DW];
    assign digit_8      = res.digits[1*DW +: DW];
    assign digit_9      = res.digits[0 +: DW];

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##6 done)
        else $error("result missing six cycles after start");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 6))
        else $error("result without a transaction");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (digit_count >= 4'd1 && digit_count <= 4'd10))
        else $error("digit count out of range");

    a_leading_digit: assert property (@(posedge clk) disable iff (!rst_n)
        done && digit_count != 4'd1 |-> digit_0 != 4'd0)
        else $error("leading zero digit in multi-digit result");

    a_tail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && digit_count != 4'd10 |-> digit_9 == 4'd0)
        else $error("unused digit position not zero");

endmodule
